[rtl/stip_pkg.sv]
// ----------------------------------------------------------------------------
// stip_pkg: shared types and constants of the sorted table interpolator
// Sequencer states, operation codes and the divider status bundle.
// ----------------------------------------------------------------------------
package stip_pkg;

    localparam int VAL_W     = 32;   // Q16.16 sample width
    localparam int FRAC_BITS = 16;   // bits of the interpolation weight
    localparam int CNT_W     = 9;    // point count register width

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LAST,
        S_FIRST,
        S_SRCH,
        S_DIVST,
        S_DIV,
        S_MUL,
        S_ADD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[rtl/sorted_table_interpolator_unit.sv]
// ----------------------------------------------------------------------------
// sorted_table_interpolator_unit: piecewise linear table interpolator
// Sorted sample table with binary search, serial fraction divide and one
// multiply to interpolate a signed Q16.16 ordinate.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one beat per item. A
//   write beat (operation 0) stores entry_x/entry_y at entry_index; it
//   gives no result. A query beat (operation 1) gives exactly one beat on
//   the output channel (o_out_valid / i_out_ready).
//   Config: pulse i_cfg_we with the point count on i_cfg_wdata while idle;
//   zero counts as one, counts above TABLE_DEPTH saturate.
//   Sequence: a query first compares against the last point, then the
//   first, and returns that point's ordinate if it is clamped there; else a
//   binary search of at most ceil(log2(point count - 1)) probes finds the
//   bracket, then a serial divide, a multiply and an add form the result. The
//   block takes no new beat while a query is in flight and is ready again
//   as the result enters the output register. A result waits in the output
//   register while the receiver stalls; a second finished result holds in
//   the sequencer until the output register frees up.
//   Reset: point count returns to one; table contents are kept and stay
//   undefined until written.
// ----------------------------------------------------------------------------
module sorted_table_interpolator_unit #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [stip_pkg::CNT_W-1:0]          i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_operation,
    input  logic [7:0]                          i_entry_index,
    input  logic signed [stip_pkg::VAL_W-1:0]   i_entry_x,
    input  logic signed [stip_pkg::VAL_W-1:0]   i_entry_y,
    input  logic signed [stip_pkg::VAL_W-1:0]   i_query_x,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [stip_pkg::VAL_W-1:0]   o_interp_value
);
    import stip_pkg::*;

    localparam int AW    = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int XW    = (AW > 8) ? AW : 8;
    localparam int PROD_W = VAL_W + FRAC_BITS + 2;

    // table: {x, y} per entry, one write and one registered read per cycle
    logic [2*VAL_W-1:0] r_mem [TABLE_DEPTH];
    logic [2*VAL_W-1:0] r_rd;

    t_state               r_state, n_state;
    logic [AW-1:0]        r_last, n_last;
    logic                 r_out_valid, n_out_valid;
    logic [AW-1:0]        r_lo, n_lo;
    logic [AW-1:0]        r_hi, n_hi;
    logic signed [VAL_W-1:0] r_qx, n_qx;
    logic signed [VAL_W-1:0] r_xlo, n_xlo;
    logic signed [VAL_W-1:0] r_ylo, n_ylo;
    logic signed [VAL_W-1:0] r_xhi, n_xhi;
    logic signed [VAL_W-1:0] r_yhi, n_yhi;
    logic signed [VAL_W-1:0] r_res, n_res;
    logic signed [VAL_W-1:0] r_out, n_out;
    logic signed [PROD_W-1:0] r_prod, n_prod;

    logic                 w_in_acc;
    logic                 w_wr_en;
    logic [XW-1:0]        w_idx_x;
    logic [AW-1:0]        w_rd_addr;
    logic signed [VAL_W-1:0] w_rd_x, w_rd_y;
    logic [AW:0]          w_sum_cur, w_sum_l, w_sum_r;
    logic [AW-1:0]        w_mid, w_mid_l, w_mid_r;
    logic                 w_gap_l, w_gap_r, w_gap_cur;
    logic                 w_div_start;
    logic [VAL_W-1:0]     w_num, w_den;
    t_div_stat            w_div_stat;
    logic [FRAC_BITS-1:0] w_quot;
    logic signed [VAL_W:0]     w_dy;
    logic signed [FRAC_BITS:0] w_wt;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_idx_x    = XW'(i_entry_index);
    assign w_wr_en    = w_in_acc && (i_operation == OP_WRITE)
                        && (32'(i_entry_index) < TABLE_DEPTH);

    assign w_rd_x = signed'(r_rd[2*VAL_W-1:VAL_W]);
    assign w_rd_y = signed'(r_rd[VAL_W-1:0]);

    // midpoint of the current bracket and of both possible next brackets
    assign w_sum_cur = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid     = w_sum_cur[AW:1];
    assign w_sum_l   = {1'b0, r_lo} + {1'b0, w_mid};
    assign w_mid_l   = w_sum_l[AW:1];
    assign w_sum_r   = {1'b0, w_mid} + {1'b0, r_hi};
    assign w_mid_r   = w_sum_r[AW:1];
    assign w_gap_cur = (r_hi - r_lo) > AW'(1);
    assign w_gap_l   = (w_mid - r_lo) > AW'(1);
    assign w_gap_r   = (r_hi - w_mid) > AW'(1);

    assign w_num = VAL_W'(r_qx - r_xlo);
    assign w_den = VAL_W'(r_xhi - r_xlo);
    assign w_dy  = (VAL_W+1)'(r_yhi) - (VAL_W+1)'(r_ylo);
    assign w_wt  = signed'({1'b0, w_quot});

    stip_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_stat  (w_div_stat),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_out_ready;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_qx        = r_qx;
        n_xlo       = r_xlo;
        n_ylo       = r_ylo;
        n_xhi       = r_xhi;
        n_yhi       = r_yhi;
        n_res       = r_res;
        n_out       = r_out;
        n_prod      = r_prod;
        w_rd_addr   = r_hi;
        w_div_start = 1'b0;

        if (i_cfg_we) begin
            priority if (i_cfg_wdata == '0) begin
                n_last = '0;
            end else if (32'(i_cfg_wdata) > TABLE_DEPTH) begin
                n_last = AW'(TABLE_DEPTH - 1);
            end else begin
                n_last = AW'(32'(i_cfg_wdata) - 1);
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_operation == OP_QUERY) begin
                    n_qx      = i_query_x;
                    n_lo      = '0;
                    n_hi      = r_last;
                    w_rd_addr = r_last;
                    n_state   = S_LAST;
                end
            end
            S_LAST: begin
                if (r_qx >= w_rd_x) begin
                    n_res   = w_rd_y;
                    n_state = S_DONE;
                end else begin
                    n_xhi     = w_rd_x;
                    n_yhi     = w_rd_y;
                    w_rd_addr = '0;
                    n_state   = S_FIRST;
                end
            end
            S_FIRST: begin
                if (r_qx <= w_rd_x) begin
                    n_res   = w_rd_y;
                    n_state = S_DONE;
                end else begin
                    n_xlo = w_rd_x;
                    n_ylo = w_rd_y;
                    if (w_gap_cur) begin
                        w_rd_addr = w_mid;
                        n_state   = S_SRCH;
                    end else begin
                        n_state = S_DIVST;
                    end
                end
            end
            S_SRCH: begin
                // narrow the bracket and issue the next probe in the same cycle
                if (r_qx < w_rd_x) begin
                    n_hi      = w_mid;
                    n_xhi     = w_rd_x;
                    n_yhi     = w_rd_y;
                    w_rd_addr = w_mid_l;
                    n_state   = w_gap_l ? S_SRCH : S_DIVST;
                end else begin
                    n_lo      = w_mid;
                    n_xlo     = w_rd_x;
                    n_ylo     = w_rd_y;
                    w_rd_addr = w_mid_r;
                    n_state   = w_gap_r ? S_SRCH : S_DIVST;
                end
            end
            S_DIVST: begin
                w_div_start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = PROD_W'(w_dy * w_wt);
                n_state = S_ADD;
            end
            S_ADD: begin
                // y_lo + floor(dy * w / 2^16); the true sum fits 32 bits
                n_res   = r_ylo + signed'(r_prod[VAL_W+FRAC_BITS-1:FRAC_BITS]);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_qx   <= n_qx;
        r_xlo  <= n_xlo;
        r_ylo  <= n_ylo;
        r_xhi  <= n_xhi;
        r_yhi  <= n_yhi;
        r_res  <= n_res;
        r_out  <= n_out;
        r_prod <= n_prod;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_idx_x[AW-1:0]] <= {i_entry_x, i_entry_y};
        end
        r_rd <= r_mem[w_rd_addr];
    end

    assign o_out_valid    = r_out_valid;
    assign o_interp_value = r_out;

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_operation == OP_QUERY) |=> !o_in_ready)
        else $error("ready after accepting a query");

    a_bracket_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_lo < r_hi))
        else $error("search bracket collapsed");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide phase");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_out_valid) |=> (o_out_valid && o_in_ready))
        else $error("result not loaded into a free output register");

endmodule

[rtl/stip_div.sv]
// ----------------------------------------------------------------------------
// stip_div: serial fraction divider
// Forms floor((num << FRAC_BITS) / den) for num < den, one quotient bit per
// cycle with a single 33-bit compare and subtract.
// ----------------------------------------------------------------------------
module stip_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [stip_pkg::VAL_W-1:0]        i_num,
    input  logic [stip_pkg::VAL_W-1:0]        i_den,
    output stip_pkg::t_div_stat               o_stat,
    output logic [stip_pkg::FRAC_BITS-1:0]    o_quot
);
    import stip_pkg::*;

    localparam int STEP_W = $clog2(FRAC_BITS + 1);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [STEP_W-1:0]    r_cnt, n_cnt;
    logic [VAL_W:0]       r_rem, n_rem;
    logic [VAL_W-1:0]     r_den, n_den;
    logic [FRAC_BITS-1:0] r_quot, n_quot;
    logic [VAL_W:0]       w_shift;
    logic                 w_ge;

    assign w_shift = {r_rem[VAL_W-1:0], 1'b0};
    assign w_ge    = w_shift >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quot = r_quot;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = STEP_W'(FRAC_BITS);
            n_rem  = {1'b0, i_num};
            n_den  = i_den;
            n_quot = '0;
        end else if (r_busy) begin
            n_rem  = w_ge ? (w_shift - {1'b0, r_den}) : w_shift;
            n_quot = {r_quot[FRAC_BITS-2:0], w_ge};
            n_cnt  = r_cnt - STEP_W'(1);
            if (r_cnt == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quot <= n_quot;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

    // remainder must stay below the divisor or the quotient bits are wrong
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < {1'b0, r_den}))
        else $error("divider remainder reached divisor");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_busy && r_cnt == STEP_W'(FRAC_BITS)))
        else $error("divider did not begin after start");

endmodule

[tb/interp_result_checker.sv]
// ----------------------------------------------------------------------------
// interp_result_checker: scoreboard for the sorted table interpolator
// Watches the config port and both streaming channels, keeps its own copy of
// the sample table and point count, predicts the interpolated ordinate of
// every query beat and compares each output beat against the oldest
// prediction.
// ----------------------------------------------------------------------------
module interp_result_checker #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [stip_pkg::CNT_W-1:0]          i_cfg_wdata,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic                                i_operation,
    input  logic [7:0]                          i_entry_index,
    input  logic signed [stip_pkg::VAL_W-1:0]   i_entry_x,
    input  logic signed [stip_pkg::VAL_W-1:0]   i_entry_y,
    input  logic signed [stip_pkg::VAL_W-1:0]   i_query_x,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [stip_pkg::VAL_W-1:0]   i_interp_value,
    output int                                  o_mismatch_count,
    output int                                  o_pending
);

    localparam longint UNIT_WEIGHT = 64'sd1 <<< stip_pkg::FRAC_BITS;

    logic signed [stip_pkg::VAL_W-1:0] x_pts [TABLE_DEPTH];
    logic signed [stip_pkg::VAL_W-1:0] y_pts [TABLE_DEPTH];
    logic [stip_pkg::CNT_W-1:0]        count_reg;
    logic signed [stip_pkg::VAL_W-1:0] expected_values [$];
    int                                mismatches;

    function automatic logic signed [stip_pkg::VAL_W-1:0] interpolate_at(
        input logic signed [stip_pkg::VAL_W-1:0] qx
    );
        int unsigned n;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        longint      num;
        longint      den;
        longint      w;
        longint      acc;
        n = count_reg;
        if (n == 0) n = 1;
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        lo = 0;
        hi = n - 1;
        if (qx >= x_pts[hi]) return y_pts[hi];
        if (qx <= x_pts[0]) return y_pts[0];
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (qx < x_pts[mid]) hi = mid;
            else lo = mid;
        end
        num = longint'(qx) - longint'(x_pts[lo]);
        den = longint'(x_pts[hi]) - longint'(x_pts[lo]);
        w   = (num * UNIT_WEIGHT) / den;
        acc = longint'(y_pts[lo]) * (UNIT_WEIGHT - w) + longint'(y_pts[hi]) * w;
        // arithmetic shift gives the floor for negative sums
        return stip_pkg::VAL_W'(acc >>> stip_pkg::FRAC_BITS);
    endfunction

    always @(posedge i_clk) begin
        logic signed [stip_pkg::VAL_W-1:0] want;
        if (!i_rst_n) begin
            count_reg = 1;
            expected_values.delete();
            mismatches = 0;
            o_pending <= 0;
            o_mismatch_count <= 0;
        end else begin
            // compare before predicting so a stray beat never meets a fresh entry
            if (i_out_valid && i_out_ready) begin
                if (expected_values.size() == 0) begin
                    $error("interp_value: no beat expected, actual %0d", i_interp_value);
                    mismatches++;
                end else begin
                    want = expected_values.pop_front();
                    if (want !== i_interp_value) begin
                        $error("interp_value: expected %0d, actual %0d", want, i_interp_value);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_operation == stip_pkg::OP_QUERY) begin
                    expected_values.insert(expected_values.size(),
                                           interpolate_at(i_query_x));
                end else if (i_entry_index < TABLE_DEPTH) begin
                    x_pts[i_entry_index] = i_entry_x;
                    y_pts[i_entry_index] = i_entry_y;
                end
            end
            if (i_cfg_we) count_reg = i_cfg_wdata;
            o_pending <= expected_values.size();
            o_mismatch_count <= mismatches;
        end
    end

endmodule

[tb/sorted_table_interpolator_unit_test.sv]
// ----------------------------------------------------------------------------
// sorted_table_interpolator_unit_test: testbench of the table interpolator
// Loads sorted, unsorted and full-depth tables, sweeps the point count over
// its extremes and fires clamped and interpolated queries with random idle
// cycles on both channels; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module sorted_table_interpolator_unit_test;

    localparam int TABLE_DEPTH    = 256;
    localparam int RANDOM_ITEMS   = 550;
    localparam int STALL_PCT      = 17;
    localparam int SETTLE_CYCLES  = 48;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic [stip_pkg::CNT_W-1:0]          i_cfg_wdata;
    logic                                i_in_valid;
    logic                                o_in_ready;
    logic                                i_operation;
    logic [7:0]                          i_entry_index;
    logic signed [stip_pkg::VAL_W-1:0]   i_entry_x;
    logic signed [stip_pkg::VAL_W-1:0]   i_entry_y;
    logic signed [stip_pkg::VAL_W-1:0]   i_query_x;
    logic                                o_out_valid;
    logic                                i_out_ready = 1'b0;
    logic signed [stip_pkg::VAL_W-1:0]   o_interp_value;

    int mismatch_total;
    int pending_results;

    logic signed [31:0] shadow_x [TABLE_DEPTH];
    logic signed [31:0] shadow_y [TABLE_DEPTH];
    int used_points = 1;
    int beats_sent  = 0;
    int write_beats = 0;
    int query_beats = 0;
    int cfg_writes  = 0;
    int random_base = 1 << 30;
    bit steady      = 1'b0;
    int idle_cycles = 0;

    sorted_table_interpolator_unit #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_entry_index  (i_entry_index),
        .i_entry_x      (i_entry_x),
        .i_entry_y      (i_entry_y),
        .i_query_x      (i_query_x),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_interp_value (o_interp_value)
    );

    interp_result_checker #(.TABLE_DEPTH(TABLE_DEPTH)) results_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_entry_index    (i_entry_index),
        .i_entry_x        (i_entry_x),
        .i_entry_y        (i_entry_y),
        .i_query_x        (i_query_x),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_interp_value   (o_interp_value),
        .o_mismatch_count (mismatch_total),
        .o_pending        (pending_results)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= STALL_PCT);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // present one beat, hold it until accepted
    task automatic send_beat(input logic op, input logic [7:0] idx,
                             input logic signed [31:0] ex, input logic signed [31:0] ey,
                             input logic signed [31:0] qx);
        while (!steady && $urandom_range(99) < STALL_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_entry_index <= idx;
        i_entry_x     <= ex;
        i_entry_y     <= ey;
        i_query_x     <= qx;
        do @(posedge i_clk); while (!o_in_ready);
        beats_sent++;
        steady = (beats_sent >= random_base + 150) && (beats_sent < random_base + 270);
    endtask

    task automatic put_point(input int idx, input logic signed [31:0] x,
                             input logic signed [31:0] y);
        shadow_x[idx] = x;
        shadow_y[idx] = y;
        write_beats++;
        send_beat(stip_pkg::OP_WRITE, 8'(idx), x, y, $urandom);
    endtask

    task automatic ask(input logic signed [31:0] qx);
        query_beats++;
        send_beat(stip_pkg::OP_QUERY, 8'($urandom), $urandom, $urandom, qx);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
    endtask

    task automatic write_point_count(input int value);
        drain_results();
        // a last write beat may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= stip_pkg::CNT_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_writes++;
        used_points = (value < 1) ? 1 : (value > TABLE_DEPTH) ? TABLE_DEPTH : value;
    endtask

    function automatic logic signed [31:0] pick_ordinate();
        case ($urandom_range(5))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return int'($urandom_range(524288)) - 262144;
            default: return $urandom;
        endcase
    endfunction

    // fill entries 0..n-1 with strictly increasing abscissas
    task automatic load_sorted(input int n, input bit wide_only);
        longint             cursor;
        longint             max_gap;
        logic signed [31:0] xs [TABLE_DEPTH];
        int                 style;
        bit                 descend;
        style   = wide_only ? 0 : $urandom_range(2);
        descend = $urandom_range(1);
        max_gap = (n > 1) ? (64'd4294967295 / n) : 64'd4294967295;
        case (style)
            0: cursor = longint'(VAL_MIN) + longint'($urandom_range(32'(max_gap - 1)));
            default: cursor = longint'($urandom_range(2000000)) - 1000000;
        endcase
        for (int k = 0; k < n; k++) begin
            xs[k] = 32'(cursor);
            case (style)
                0: cursor += longint'($urandom_range(32'(max_gap), 1));
                1: cursor += longint'($urandom_range(8, 1));
                default: cursor += longint'($urandom_range(262144, 1));
            endcase
        end
        for (int k = 0; k < n; k++) begin
            if (descend) put_point(n - 1 - k, xs[n - 1 - k], pick_ordinate());
            else put_point(k, xs[k], pick_ordinate());
        end
    endtask

    function automatic logic signed [31:0] pick_query();
        longint lo;
        longint hi;
        longint q;
        int     k;
        int     r;
        r = $urandom_range(9);
        if (r == 0 || (used_points < 2 && r > 2)) return $urandom;
        if (r == 1) return shadow_x[$urandom_range(used_points - 1)];
        if (r == 2) begin
            q = $urandom_range(1) ? longint'(shadow_x[0]) : longint'(shadow_x[used_points - 1]);
            q = q + longint'($urandom_range(4)) - 2;
            if (q > longint'(VAL_MAX)) q = VAL_MAX;
            if (q < longint'(VAL_MIN)) q = VAL_MIN;
            return 32'(q);
        end
        k  = $urandom_range(used_points - 2);
        lo = shadow_x[k];
        hi = shadow_x[k + 1];
        if (hi <= lo) return $urandom;
        q = lo + longint'(({$urandom, $urandom} & 64'h7fff_ffff_ffff_ffff) % (hi - lo));
        return 32'(q);
    endfunction

    // mostly queries, a few stray writes that may unsort the table
    task automatic run_queries(input int beats);
        for (int k = 0; k < beats; k++) begin
            if ($urandom_range(39) == 0) drain_results();
            if ($urandom_range(99) < 8) put_point($urandom_range(TABLE_DEPTH - 1), $urandom,
                                                  $urandom);
            else ask(pick_query());
        end
    endtask

    initial begin
        int count_pick;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_in_valid    = 1'b0;
        i_operation   = stip_pkg::OP_WRITE;
        i_entry_index = '0;
        i_entry_x     = '0;
        i_entry_y     = '0;
        i_query_x     = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single point after reset: every query returns entry zero
        put_point(0, 32'sh0001_0000, 32'sh0003_8000);
        ask(VAL_MIN);
        ask(VAL_MAX);
        ask(32'sh0001_0000);
        put_point(TABLE_DEPTH - 1, VAL_MAX, VAL_MAX);
        write_point_count(0);
        ask(32'sh1234_5678);

        // two points at the extremes of the range
        write_point_count(2);
        put_point(0, VAL_MIN, VAL_MIN);
        put_point(1, VAL_MAX, VAL_MAX);
        ask(VAL_MIN);
        ask(VAL_MAX);
        ask(0);
        ask(VAL_MIN + 1);
        ask(VAL_MAX - 1);

        // negative fractional result must round down
        put_point(0, 0, 0);
        put_point(1, 3, -1);
        ask(1);
        ask(2);

        // unsorted table
        write_point_count(3);
        put_point(0, -100, 1000);
        put_point(1, 500, -2000);
        put_point(2, 100, VAL_MAX);
        ask(0);
        ask(99);

        random_base = beats_sent;

        // full depth under a saturated count, then the exact maximum
        write_point_count(511);
        load_sorted(TABLE_DEPTH, 1'b1);
        run_queries(60);
        write_point_count(TABLE_DEPTH);
        run_queries(40);

        while (beats_sent - random_base < RANDOM_ITEMS) begin
            case ($urandom_range(9))
                0: count_pick = 0;
                1: count_pick = $urandom_range(511, TABLE_DEPTH + 1);
                2: count_pick = $urandom_range(TABLE_DEPTH, 25);
                default: count_pick = $urandom_range(24, 1);
            endcase
            write_point_count(count_pick);
            if (used_points <= 24) load_sorted(used_points, 1'b0);
            run_queries($urandom_range(35, 15));
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d table writes, %0d queries, %0d point-count writes",
                 write_beats, query_beats, cfg_writes);
        $display("tables: single point, range extremes, unsorted, sorted up to full depth");
        if (mismatch_total == 0 && pending_results == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
